[design/chd_pkg.sv]
`default_nettype none
package chd_pkg;
   localparam int MaxSymbols = 512;
   localparam int MaxCodeWidth = 16;
   localparam int IdxW = $clog2(MaxSymbols);
   localparam int CntW = $clog2(MaxSymbols + 1);
   localparam int WidW = $clog2(MaxCodeWidth);
   localparam logic [4:0] NoWidth = 5'd17;
   localparam logic [15:0] EmptySymbol = 16'hFFFF;
   localparam logic [1:0] StOk = 2'd0;
   localparam logic [1:0] StNotFound = 2'd1;
   localparam logic [1:0] StRanOut = 2'd2;
   localparam logic [1:0] StFull = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic load;        // accept load request
      logic lookup_go;   // accept lookup request
      logic scan_clr;    // start min/max scan
      logic scan_step;   // process pair list read data in scan
      logic width_init;  // open a width in assign pass
      logic asg_step;    // process pair list read data in assign
      logic width_close; // close a width
      logic build_done;  // finish build
      logic lookup_fin;  // finish lookup and report result
      logic load_fin;    // report load result
   } cmd_type;

   typedef struct packed {
      logic last_pair;   // read pointer at final pair
      logic last_width;  // current width is MaxCodeWidth
      logic empty_list;  // no pairs
   } stat_type;
endpackage
`default_nettype wire

[design/canonical_huffman_decoder.sv]
`default_nettype none
// canonical huffman decoder
// request channel: start/busy; a request is taken at a clock edge with start
// high and busy low. req_action 0 loads a (symbol, width) pair, 1 looks up a
// right aligned code of req_width_in bits. req_last_entry on a load starts
// the table build.
// response channel: rsp_valid strobes for one cycle per request with status,
// symbol, and the current min/max code widths. there is no back pressure;
// the receiver must take the response in that cycle.
// a load without last mark answers in the cycle after acceptance; a lookup
// answers after the S_LOOK state (the sorted symbol memory read is registered).
// a build for N loaded pairs makes one scan over the pair list for min/max,
// then one pass over the list per width 1..16, limited by the single read
// port of the pair memory.
// busy stays high through lookup and build; throughput is one request per
// cycle for loads without last mark; a lookup holds busy through S_LOOK.
// reset clears the list count, widths and per-width tables; the memories
// are not cleared (entries are only read after being written).
module canonical_huffman_decoder import chd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_action,
   input  wire logic [15:0] req_symbol_in,
   input  wire logic [4:0]  req_width_in,
   input  wire logic [15:0] req_code_in,
   input  wire logic        req_last_entry,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_symbol_out,
   output logic [4:0]       rsp_min_width,
   output logic [4:0]       rsp_max_width
);
   cmd_type  cmd;
   stat_type stat;

   // sequencer for load, lookup and build
   chd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_action(req_action),
      .req_last_entry(req_last_entry), .stat(stat), .busy(busy), .cmd(cmd));

   // pair memory, symbol memory and per-width tables
   chd_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_symbol_in(req_symbol_in),
      .req_width_in(req_width_in), .req_code_in(req_code_in), .stat(stat),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_symbol_out(rsp_symbol_out), .rsp_min_width(rsp_min_width),
      .rsp_max_width(rsp_max_width));

   // a lookup always answers once its S_LOOK state has registered the response
   a_lookup_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_action) |=> ##1 rsp_valid) else $error("lookup lost");
   // a non-final load answers next cycle
   a_load_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_action && !req_last_entry) |=> rsp_valid)
      else $error("load lost");
   // responses other than ok (not found, full, ran out) carry no symbol
   a_sym_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != StOk) |-> rsp_symbol_out == 16'd0)
      else $error("symbol on miss");
endmodule
`default_nettype wire

[design/chd_ram.sv]
`default_nettype none
module chd_ram #(
   parameter int Width = 16,
   parameter int Depth = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[design/chd_ctrl.sv]
`default_nettype none
module chd_ctrl import chd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire logic     req_action,
   input  wire logic     req_last_entry,
   input  wire stat_type stat,
   output logic          busy,
   output cmd_type       cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOOK = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_WINIT = 3'd3;
   localparam logic [2:0] S_ASG = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;
   localparam logic [2:0] S_PRE = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               if (req_action) begin
                  cmd.lookup_go = 1'b1;
                  state_in = S_LOOK;
               end else begin
                  cmd.load = 1'b1;
                  if (req_last_entry) state_in = S_PRE;
                  else cmd.load_fin = 1'b1;
               end
            end
         end
         S_LOOK: begin
            cmd.lookup_fin = 1'b1;
            state_in = S_IDLE;
         end
         S_PRE: begin
            cmd.scan_clr = 1'b1;
            state_in = stat.empty_list ? S_WINIT : S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.last_pair) state_in = S_WINIT;
         end
         S_WINIT: begin
            cmd.width_init = 1'b1;
            if (stat.empty_list) begin
               cmd.width_close = 1'b1;
               if (stat.last_width) state_in = S_DONE;
            end else state_in = S_ASG;
         end
         S_ASG: begin
            cmd.asg_step = 1'b1;
            if (stat.last_pair) begin
               cmd.width_close = 1'b1;
               state_in = stat.last_width ? S_DONE : S_WINIT;
            end
         end
         S_DONE: begin
            cmd.build_done = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

[design/chd_datapath.sv]
`default_nettype none
module chd_datapath import chd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   input  wire logic [15:0] req_symbol_in,
   input  wire logic [4:0]  req_width_in,
   input  wire logic [15:0] req_code_in,
   output stat_type         stat,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_symbol_out,
   output logic [4:0]       rsp_min_width,
   output logic [4:0]       rsp_max_width
);
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] rptr_ff;
   logic [4:0] minw_ff, maxw_ff;
   logic [4:0] wcur_ff;
   logic [16:0] code_ff;
   logic [CntW-1:0] idx_ff;
   logic ranout_ff, full_ff;
   logic [CntW-1:0] cnt_ff [MaxCodeWidth];
   logic [16:0] first_ff [MaxCodeWidth];
   logic [CntW-1:0] base_ff [MaxCodeWidth];
   logic [1:0] lk_stat_ff;
   logic valid_ff;
   logic [1:0] status_ff;
   logic [15:0] sym_ff;

   logic [20:0] pl_rd;
   logic [15:0] ss_rd;
   logic [IdxW-1:0] pl_raddr;
   logic [IdxW-1:0] ss_raddr;
   logic [4:0] pw;
   logic [WidW-1:0] wsel;
   logic [WidW-1:0] lsel;
   logic [16:0] lcode;
   logic [16:0] diff;
   logic lk_hit;
   logic [CntW-1:0] lidx;
   logic list_full;

   assign list_full = (count_ff == CntW'(MaxSymbols));
   chd_ram #(.Width(21), .Depth(MaxSymbols)) u_pairs (
      .clock(clock), .wr_en(cmd.load && !list_full),
      .wr_addr(count_ff[IdxW-1:0]), .wr_data({req_symbol_in, req_width_in}),
      .rd_addr(pl_raddr), .rd_data(pl_rd));

   // read address runs one ahead of processing
   always_comb begin
      pl_raddr = rptr_ff[IdxW-1:0];
      if (cmd.scan_clr || cmd.width_init || (cmd.asg_step && stat.last_pair))
         pl_raddr = '0;
      else if (cmd.scan_step || cmd.asg_step)
         pl_raddr = IdxW'(rptr_ff + 1'b1);
   end

   assign pw = (pl_rd[4:0] > 5'(MaxCodeWidth)) ? 5'd0 : pl_rd[4:0];
   assign wsel = WidW'(wcur_ff - 5'd1);
   assign stat.last_pair = (rptr_ff == CntW'(count_ff - 1'b1));
   assign stat.last_width = (wcur_ff == 5'(MaxCodeWidth));
   assign stat.empty_list = (count_ff == '0);

   logic asg_ok;
   assign asg_ok = (code_ff < (17'd1 << wcur_ff)) && (idx_ff < CntW'(MaxSymbols));
   chd_ram #(.Width(16), .Depth(MaxSymbols)) u_syms (
      .clock(clock), .wr_en(cmd.asg_step && pw == wcur_ff && asg_ok),
      .wr_addr(idx_ff[IdxW-1:0]), .wr_data(pl_rd[20:5]),
      .rd_addr(ss_raddr), .rd_data(ss_rd));

   // lookup stage one: range checks and index
   assign lsel = WidW'(req_width_in - 5'd1);
   assign lcode = {1'b0, req_code_in};
   assign diff = lcode - first_ff[lsel];
   always_comb begin
      lk_hit = (req_width_in != 0) && (req_width_in <= maxw_ff)
         && (req_width_in <= 5'(MaxCodeWidth))
         && ({1'b0, req_code_in} < (17'd1 << req_width_in))
         && (lcode >= first_ff[lsel]) && (diff < 17'(cnt_ff[lsel]));
      lidx = CntW'(base_ff[lsel] + diff[CntW-1:0]);
      if (lidx >= CntW'(MaxSymbols)) lk_hit = 1'b0;
      ss_raddr = lidx[IdxW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         minw_ff <= '0;
         maxw_ff <= '0;
         valid_ff <= 1'b0;
         for (int k = 0; k < MaxCodeWidth; k++) begin
            cnt_ff[k] <= '0;
            first_ff[k] <= '0;
            base_ff[k] <= '0;
         end
      end else begin
         valid_ff <= 1'b0;
         if (cmd.load) begin
            full_ff <= list_full;
            ranout_ff <= 1'b0;
            if (!list_full) count_ff <= CntW'(count_ff + 1'b1);
         end
         if (cmd.load_fin) begin
            valid_ff <= 1'b1;
            status_ff <= list_full ? StFull : StOk;
            sym_ff <= '0;
         end
         if (cmd.lookup_go) lk_stat_ff <= lk_hit ? StOk : StNotFound;
         if (cmd.lookup_fin) begin
            valid_ff <= 1'b1;
            if (lk_stat_ff == StOk && ss_rd != EmptySymbol) begin
               status_ff <= StOk;
               sym_ff <= ss_rd;
            end else begin
               status_ff <= StNotFound;
               sym_ff <= '0;
            end
         end
         if (cmd.scan_clr) begin
            minw_ff <= NoWidth;
            maxw_ff <= '0;
            rptr_ff <= '0;
            wcur_ff <= 5'd1;
            code_ff <= '0;
            idx_ff <= '0;
         end
         if (cmd.scan_step) begin
            if (pw != 0 && pw < minw_ff) minw_ff <= pw;
            if (pw > maxw_ff) maxw_ff <= pw;
            rptr_ff <= stat.last_pair ? '0 : CntW'(rptr_ff + 1'b1);
         end
         if (cmd.width_init) begin
            first_ff[wsel] <= code_ff;
            base_ff[wsel] <= idx_ff;
            rptr_ff <= '0;
         end
         if (cmd.asg_step) begin
            if (pw == wcur_ff) begin
               if (asg_ok) begin
                  idx_ff <= CntW'(idx_ff + 1'b1);
                  code_ff <= code_ff + 17'd1;
               end else ranout_ff <= 1'b1;
            end
            rptr_ff <= stat.last_pair ? '0 : CntW'(rptr_ff + 1'b1);
         end
         if (cmd.width_close) begin
            // idx/code after this step's increment
            logic [CntW-1:0] ni;
            logic [16:0] nc;
            ni = idx_ff;
            nc = code_ff;
            if (cmd.asg_step && pw == wcur_ff && asg_ok) begin
               ni = CntW'(idx_ff + 1'b1);
               nc = code_ff + 17'd1;
            end
            cnt_ff[wsel] <= CntW'(ni - (cmd.width_init ? idx_ff : base_ff[wsel]));
            code_ff <= {nc[15:0], 1'b0};
            idx_ff <= ni;
            wcur_ff <= wcur_ff + 5'd1;
         end
         if (cmd.build_done) begin
            count_ff <= '0;
            valid_ff <= 1'b1;
            sym_ff <= '0;
            status_ff <= full_ff ? StFull
               : ((ranout_ff || (cmd.asg_step && !asg_ok)) ? StRanOut : StOk);
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_status = status_ff;
   assign rsp_symbol_out = sym_ff;
   assign rsp_min_width = minw_ff;
   assign rsp_max_width = maxw_ff;
endmodule
`default_nettype wire

[dv/chd_checker.sv]
module chd_checker import chd_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic        req_action,
   input  wire logic [15:0] req_symbol_in,
   input  wire logic [4:0]  req_width_in,
   input  wire logic [15:0] req_code_in,
   input  wire logic        req_last_entry,
   input  wire logic        rsp_valid,
   input  wire logic [1:0]  rsp_status,
   input  wire logic [15:0] rsp_symbol_out,
   input  wire logic [4:0]  rsp_min_width,
   input  wire logic [4:0]  rsp_max_width,
   output int               fail_count,
   output int               pending,
   output int               hit_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] symbol;
      logic [4:0]  min_width;
      logic [4:0]  max_width;
   } outcome_type;

   outcome_type expected_outcomes[$];

   // shadow copy of the decoder tables
   logic [15:0] list_symbol[MaxSymbols];
   logic [4:0]  list_width[MaxSymbols];
   int          list_len;
   logic [4:0]  shortest, longest;
   int          width_count[1:MaxCodeWidth];
   int          width_first[1:MaxCodeWidth];
   int          width_base[1:MaxCodeWidth];
   logic [15:0] table_symbol[MaxSymbols];

   // widths above the maximum act as unused
   function automatic int usable_width(logic [4:0] w);
      return (w > MaxCodeWidth) ? 0 : int'(w);
   endfunction

   // returns 1 when some pair got no code
   function automatic bit build_code_table();
      int  code, idx, w;
      bit  ran_out;
      code = 0;
      idx = 0;
      ran_out = 0;
      shortest = NoWidth;
      longest = '0;
      for (int i = 0; i < list_len; i++) begin
         w = usable_width(list_width[i]);
         if (w != 0 && w < shortest) shortest = 5'(w);
         if (w > longest) longest = 5'(w);
      end
      for (int cw = 1; cw <= MaxCodeWidth; cw++) begin
         width_first[cw] = code;
         width_base[cw] = idx;
         for (int i = 0; i < list_len; i++) begin
            if (usable_width(list_width[i]) != cw) continue;
            if (code < (1 << cw) && idx < MaxSymbols) begin
               table_symbol[idx] = list_symbol[i];
               idx++;
               code++;
            end else begin
               ran_out = 1;
            end
         end
         width_count[cw] = idx - width_base[cw];
         code = (code << 1) & 32'h1FFFF;
      end
      list_len = 0;
      return ran_out;
   endfunction

   function automatic outcome_type decode_request(logic action, logic [15:0] sym,
                                                  logic [4:0] w, logic [15:0] code,
                                                  logic last);
      outcome_type o;
      int          first, idx;
      o = '0;
      o.status = StOk;
      if (!action) begin
         if (list_len < MaxSymbols) begin
            list_symbol[list_len] = sym;
            list_width[list_len] = w;
            list_len++;
         end else begin
            o.status = StFull;
         end
         if (last && build_code_table() && o.status == StOk) o.status = StRanOut;
      end else begin
         o.status = StNotFound;
         if (w != 0 && w <= longest && w <= MaxCodeWidth && int'(code) < (1 << w)) begin
            first = width_first[w];
            if (int'(code) >= first && int'(code) - first < width_count[w]) begin
               idx = width_base[w] + int'(code) - first;
               if (idx < MaxSymbols && table_symbol[idx] != EmptySymbol) begin
                  o.status = StOk;
                  o.symbol = table_symbol[idx];
               end
            end
         end
      end
      o.min_width = shortest;
      o.max_width = longest;
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         list_len = 0;
         shortest = '0;
         longest = '0;
         for (int cw = 1; cw <= MaxCodeWidth; cw++) begin
            width_count[cw] = 0;
            width_first[cw] = 0;
            width_base[cw] = 0;
         end
         expected_outcomes.delete();
         fail_count <= 0;
         hit_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_outcomes.size() == 0) begin
               $error("response with no request outstanding: status %0d symbol %0h",
                      rsp_status, rsp_symbol_out);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_status != want.status ||
                   rsp_symbol_out != want.symbol ||
                   rsp_min_width != want.min_width ||
                   rsp_max_width != want.max_width)
                  fail_count <= fail_count + 1;
               if (rsp_status != want.status)
                  $error("status expected %0d got %0d", want.status, rsp_status);
               if (rsp_symbol_out != want.symbol)
                  $error("symbol_out expected %0h got %0h", want.symbol, rsp_symbol_out);
               if (rsp_min_width != want.min_width)
                  $error("min_width expected %0d got %0d", want.min_width, rsp_min_width);
               if (rsp_max_width != want.max_width)
                  $error("max_width expected %0d got %0d", want.max_width, rsp_max_width);
               if (want.status == StOk && rsp_status == StOk && rsp_symbol_out == want.symbol
                   && want.symbol != 0)
                  hit_count <= hit_count + 1;
            end
         end
         if (start && !busy)
            expected_outcomes.push_back(decode_request(req_action, req_symbol_in,
                                                       req_width_in, req_code_in,
                                                       req_last_entry));
      end
      pending <= expected_outcomes.size();
   end
endmodule

[dv/tb_top.sv]
module tb_top import chd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // cycles with no request or response taken before the run is abandoned;
   // the limit lies above the longest build (a full list)
   localparam int StallLimit = 40000;
   localparam int TargetItems = 1750;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_action;
   logic [15:0] req_symbol_in;
   logic [4:0]  req_width_in;
   logic [15:0] req_code_in;
   logic        req_last_entry;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_symbol_out;
   logic [4:0]  rsp_min_width;
   logic [4:0]  rsp_max_width;

   int fail_count, pending, hit_count;
   int idle_pct;
   int n_requests, n_loads, n_lookups, n_builds;
   int quiet_cycles;

   canonical_huffman_decoder dut (.*);

   chd_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // watchdog: nothing moving on either channel for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("canonical_huffman_decoder test failed");
            $finish;
         end
      end
   end

   // one request; a random gap first depending on the idle phase
   task automatic issue(logic action, logic [15:0] sym, logic [4:0] w,
                        logic [15:0] code, logic last);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 6) gap++;
      repeat (gap) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_action <= action;
      req_symbol_in <= sym;
      req_width_in <= w;
      req_code_in <= code;
      req_last_entry <= last;
      do @(posedge clock); while (busy);
      n_requests++;
      if (action) n_lookups++;
      else n_loads++;
      if (!action && last) n_builds++;
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic lookup(logic [4:0] w, logic [15:0] code);
      issue(1'b1, 16'($urandom), w, code, 1'($urandom_range(1)));
   endtask

   task automatic load(logic [15:0] sym, logic [4:0] w, logic last);
      issue(1'b0, sym, w, 16'($urandom), last);
   endtask

   // pick a symbol, now and then the empty marker or an extreme
   function automatic logic [15:0] pick_symbol();
      case ($urandom_range(9))
         0: return EmptySymbol;
         1: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int n_pairs, top_width, n_lookup, w, kind;
      bit big_done;
      reset = 1;
      start = 0;
      req_action = 0;
      req_symbol_in = 0;
      req_width_in = 0;
      req_code_in = 0;
      req_last_entry = 0;
      idle_pct = 0;
      big_done = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: lookups with no table yet
      lookup(5'd1, 16'd0);
      lookup(5'd0, 16'd0);
      // a small list with unused widths, an empty marker and a width 16 that runs out
      load(16'h0000, 5'd1, 1'b0);
      load(EmptySymbol, 5'd2, 1'b0);
      load(16'h1234, 5'd0, 1'b0);
      load(16'hABCD, 5'd17, 1'b0);
      load(16'h5555, 5'd31, 1'b0);
      load(16'hAAAA, 5'd3, 1'b0);
      load(16'h00FF, 5'd16, 1'b0);
      load(16'hFFFE, 5'd3, 1'b1);
      lookup(5'd1, 16'd0);       // hit on symbol zero
      lookup(5'd2, 16'd2);       // stored empty marker reads as a miss
      lookup(5'd3, 16'd6);
      lookup(5'd3, 16'd7);
      lookup(5'd3, 16'd8);       // code too wide for its width
      lookup(5'd16, 16'hFFFF);
      lookup(5'd4, 16'd0);       // no symbols of that width
      lookup(5'd0, 16'd0);
      lookup(5'd17, 16'd1);      // above the longest width
      lookup(5'd31, 16'hFFFF);
      // three width 1 codes cannot all fit
      load(16'h0001, 5'd1, 1'b0);
      load(16'h0002, 5'd1, 1'b0);
      load(16'h0003, 5'd1, 1'b1);
      lookup(5'd1, 16'd1);
      drain();

      // random: mostly a table build followed by lookups into it
      while (n_requests < TargetItems) begin
         case ($urandom_range(3))
            0: idle_pct = 0;
            1: idle_pct = 55;
            2: idle_pct = 9;
            default: idle_pct = $urandom_range(1) ? 0 : 55;
         endcase
         kind = $urandom_range(19);
         if (!big_done && n_requests > TargetItems / 3) begin
            // overfill the list: the last few loads are dropped
            big_done = 1;
            for (int i = 0; i < MaxSymbols + 6; i++)
               load(pick_symbol(), 5'($urandom_range(1, MaxCodeWidth)),
                    i == MaxSymbols + 5);
            for (int i = 0; i < 40; i++) begin
               w = $urandom_range(1, MaxCodeWidth);
               lookup(5'(w), 16'($urandom & ((1 << w) - 1)));
            end
         end else if (kind < 17) begin
            top_width = ($urandom_range(3) == 0) ? $urandom_range(1, MaxCodeWidth)
                                                 : $urandom_range(1, 5);
            n_pairs = $urandom_range(1, 20);
            for (int i = 0; i < n_pairs; i++) begin
               case ($urandom_range(15))
                  0: w = 0;
                  1: w = $urandom_range(17, 31);
                  default: w = $urandom_range(1, top_width);
               endcase
               load(pick_symbol(), 5'(w), i == n_pairs - 1);
            end
            n_lookup = $urandom_range(4, 30);
            for (int i = 0; i < n_lookup; i++) begin
               w = $urandom_range(0, top_width + 1);
               if ($urandom_range(7) == 0) lookup(5'($urandom), 16'($urandom));
               else lookup(5'(w), 16'($urandom & ((1 << w) - 1)));
            end
         end else begin
            // noise: anything at all, builds now and then
            for (int i = 0; i < 10; i++)
               issue(1'($urandom_range(1)), 16'($urandom), 5'($urandom), 16'($urandom),
                     $urandom_range(7) == 0);
         end
         // hold off now and then until every response has come back
         if ($urandom_range(9) == 0) drain();
      end

      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d requests: %0d loads, %0d builds, %0d lookups (%0d nonzero hits)",
               n_requests, n_loads, n_builds, n_lookups, hit_count);
      if (fail_count == 0) begin
         $display("canonical_huffman_decoder test passed");
      end else begin
         $display("canonical_huffman_decoder test failed");
      end
      $finish;
   end
endmodule
